// File: design/btcs_pkg.sv
// Shared types, codes and helpers for the binomial-tree collective scheduler.
package btcs_pkg;

  localparam int RANK_W = 6;
  localparam int SIZE_W = 7;
  localparam int MAP_W  = 64;
  localparam int LV_W   = 4;
  localparam int TL_W   = 3;
  localparam int DATA_W = 64;

  localparam logic [LV_W-1:0] LV_FIN = 4'd8;

  typedef enum logic [1:0] {
    ACT_START_RED = 2'd0,
    ACT_RED_MSG   = 2'd1,
    ACT_START_BC  = 2'd2,
    ACT_BC_MSG    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_RECV = 2'd1,
    KIND_FIN  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_OWN_RANK   = 2'd0,
    REG_GROUP_SIZE = 2'd1,
    REG_INIT_EXCL  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_RED  = 3'b010,
    PH_BRC  = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  typedef struct packed {
    logic              parent;
    logic              child;
    logic [RANK_W-1:0] up;
    logic [RANK_W-1:0] dn;
  } lvl_res_t;

  typedef struct packed {
    kind_e             kind;
    logic [RANK_W-1:0] partner;
    logic [TL_W-1:0]   tree_level;
    logic              self_excl;
    logic              last;
  } result_t;

  // Top tree level: ceil(log2(size)) + 1
  function automatic logic [LV_W-1:0] top_level(input logic [SIZE_W-1:0] size);
    logic [LV_W-1:0] c;
    c = 4'd1;
    for (int i = 0; i < 6; i++) begin
      if (size > (7'd1 << i)) c = c + 4'd1;
    end
    return c;
  endfunction

endpackage

// File: design/btcs_level_unit.sv
// Shared level unit: partner ranks and tree role of one rank at one level.
module btcs_level_unit (
  input  logic [btcs_pkg::RANK_W-1:0] rank_i,
  input  logic [btcs_pkg::LV_W-1:0]   lv_i,
  input  logic [btcs_pkg::SIZE_W-1:0] size_i,
  output btcs_pkg::lvl_res_t          res_o
);
  import btcs_pkg::*;

  logic [2:0] sh;
  logic [6:0] half;
  logic [7:0] mask;
  logic [7:0] low;
  logic [7:0] up_sum;

  always_comb begin
    sh     = 3'(lv_i - 4'd1);
    half   = 7'd1 << sh;
    mask   = {half, 1'b0} - 8'd1;
    low    = {2'b00, rank_i} & mask;
    up_sum = {2'b00, rank_i} + {1'b0, half};
    res_o.parent = (low == 8'd0) && (up_sum < {1'b0, size_i});
    res_o.child  = (low == {1'b0, half});
    res_o.up     = up_sum[RANK_W-1:0];
    res_o.dn     = rank_i - half[RANK_W-1:0];
  end

endmodule

// File: design/btcs_seq.sv
// Event sequencer: one level per unstalled cycle; keeps map, level and phase.
module btcs_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [btcs_pkg::RANK_W-1:0] own_rank_i,
  input  logic [btcs_pkg::SIZE_W-1:0] size_i,
  input  logic [btcs_pkg::LV_W-1:0]   lmax_i,
  input  logic [btcs_pkg::MAP_W-1:0]  init_excl_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  btcs_pkg::action_e           in_action_i,
  input  logic [btcs_pkg::RANK_W-1:0] in_src_i,
  input  logic                        in_rx_empty_i,
  input  logic                        in_loc_empty_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output btcs_pkg::result_t           out_o
);
  import btcs_pkg::*;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [MAP_W-1:0]  map_q, map_d;
  logic [TL_W-1:0]   level_q, level_d;
  logic [LV_W-1:0]   lv_q, lv_d;
  logic              bcast_q, bcast_d;
  logic              walked_q, walked_d;
  logic              lemp_q, lemp_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  lvl_res_t          lres;
  logic              in_group;
  logic              accept;
  logic              out_free;
  logic              done;
  logic              start;
  logic [LV_W-1:0]   next_lv;

  btcs_level_unit u_level (
    .rank_i (own_rank_i),
    .lv_i   (lv_q),
    .size_i (size_i),
    .res_o  (lres)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign in_group    = ({1'b0, own_rank_i} < size_i);
  assign out_free    = !out_valid_q || out_ready_i;
  assign done        = bcast_q ? (lv_q == '0) : (lv_q > lmax_i);
  assign next_lv     = bcast_q ? (lv_q - 4'd1) : (lv_q + 4'd1);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    map_d       = map_q;
    level_d     = level_q;
    lv_d        = lv_q;
    bcast_d     = bcast_q;
    walked_d    = walked_q;
    lemp_d      = lemp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    start       = 1'b0;

    if (accept) begin
      lemp_d   = in_loc_empty_i;
      lv_d     = LV_FIN;
      bcast_d  = 1'b0;
      walked_d = 1'b0;
      case (in_action_i)
        ACT_START_RED: begin
          start = 1'b1;
          map_d = init_excl_i;
          if (in_group && !init_excl_i[own_rank_i]) begin
            lv_d     = 4'd1;
            walked_d = 1'b1;
          end
        end
        ACT_RED_MSG: begin
          if (phase_q == PH_RED) begin
            start = 1'b1;
            if (in_group) begin
              if (in_rx_empty_i) map_d[in_src_i] = 1'b1;
              lv_d     = {1'b0, level_q} + 4'd1;
              walked_d = (({1'b0, level_q} + 4'd1) <= lmax_i);
            end
          end
        end
        ACT_START_BC: begin
          start = 1'b1;
          if (in_group && !map_q[own_rank_i]) begin
            lv_d    = lmax_i;
            bcast_d = 1'b1;
          end
        end
        ACT_BC_MSG: begin
          if (phase_q == PH_BRC) begin
            start = 1'b1;
            if (in_group) begin
              lv_d    = {1'b0, level_q} - {3'b000, (level_q != '0)};
              bcast_d = 1'b1;
            end
          end
        end
        default: start = 1'b0;
      endcase
      if (start) state_d = ST_WALK;
    end else if (state_q == ST_WALK && out_free) begin
      out_d.self_excl = map_q[own_rank_i];
      out_d.last      = 1'b0;
      lv_d            = next_lv;
      if (done) begin
        if (!bcast_q && walked_q && lemp_q) map_d[own_rank_i] = 1'b1;
        out_valid_d      = 1'b1;
        out_d.kind       = KIND_FIN;
        out_d.partner    = '0;
        out_d.tree_level = '0;
        out_d.self_excl  = map_q[own_rank_i] || (!bcast_q && walked_q && lemp_q);
        out_d.last       = 1'b1;
        phase_d          = PH_IDLE;
        state_d          = ST_IDLE;
      end else if (!bcast_q) begin
        if (lres.parent) begin
          if (!map_q[lres.up]) begin
            out_valid_d      = 1'b1;
            out_d.kind       = KIND_RECV;
            out_d.partner    = lres.up;
            out_d.tree_level = lv_q[TL_W-1:0];
            out_d.last       = 1'b1;
            level_d          = lv_q[TL_W-1:0];
            phase_d          = PH_RED;
            state_d          = ST_IDLE;
          end
        end else if (lres.child && !map_q[lres.dn]) begin
          out_valid_d      = 1'b1;
          out_d.kind       = KIND_SEND;
          out_d.partner    = lres.dn;
          out_d.tree_level = lv_q[TL_W-1:0];
        end
      end else begin
        if (lres.parent) begin
          if (!map_q[lres.up]) begin
            out_valid_d      = 1'b1;
            out_d.kind       = KIND_SEND;
            out_d.partner    = lres.up;
            out_d.tree_level = lv_q[TL_W-1:0];
          end
        end else if (lres.child) begin
          out_valid_d      = 1'b1;
          out_d.kind       = KIND_RECV;
          out_d.partner    = lres.dn;
          out_d.tree_level = lv_q[TL_W-1:0];
          out_d.last       = 1'b1;
          level_d          = lv_q[TL_W-1:0];
          phase_d          = PH_BRC;
          state_d          = ST_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      map_q       <= '0;
      level_q     <= '0;
      lv_q        <= '0;
      bcast_q     <= 1'b0;
      walked_q    <= 1'b0;
      lemp_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      map_q       <= map_d;
      level_q     <= level_d;
      lv_q        <= lv_d;
      bcast_q     <= bcast_d;
      walked_q    <= walked_d;
      lemp_q      <= lemp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// File: design/binomial_tree_collective_scheduler_top.sv
// Top level of the binomial-tree reduce/broadcast scheduler for one rank.
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tuser: action; tdata: source, flags
//  m_axis    out  tvalid/tready, tlast    tuser: kind; tdata: partner, level, self
//  cfg       in   cfg_we_i (no ready)     cfg_idx_i selects, cfg_data_i value
//
// A started event walks the tree levels, one level per cycle while the result
// register is free; the level loop runs on one shared add/compare unit.
// An arrival that is not awaited is dropped in its accept cycle.
// Reset (rst_ni low, async) clears map, level, phase and all handshake state.
// Stalls: while the result register holds an untaken beat the walk freezes;
// s_axis_tready is high only between events.
module binomial_tree_collective_scheduler_top #(
  parameter int MAX_RANKS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [btcs_pkg::DATA_W-1:0] cfg_data_i,
  // event input
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [5:0] source_rank, [6] received_empty,
                                                     // [7] local_empty
  input  logic [1:0]                  s_axis_tuser,  // [1:0] action
  // schedule output
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,  // [5:0] partner_rank, [8:6] tree_level,
                                                     // [9] self_excluded, rest zero
  output logic [1:0]                  m_axis_tuser,  // [1:0] kind
  output logic                        m_axis_tlast
);
  import btcs_pkg::*;

  logic [RANK_W-1:0] own_rank_q;
  logic [SIZE_W-1:0] size_q;
  logic [MAP_W-1:0]  init_q;
  logic [SIZE_W-1:0] size_eff;
  logic [LV_W-1:0]   lmax;
  result_t           res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_rank_q <= '0;
      size_q     <= 7'd1;
      init_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OWN_RANK:   own_rank_q <= cfg_data_i[RANK_W-1:0];
        REG_GROUP_SIZE: size_q     <= cfg_data_i[SIZE_W-1:0];
        REG_INIT_EXCL:  init_q     <= cfg_data_i[MAP_W-1:0];
        default:        ;
      endcase
    end
  end

  // zero counts as one, oversize clamps to the rank limit
  always_comb begin
    if (size_q == '0) size_eff = 7'd1;
    else if (size_q > SIZE_W'(MAX_RANKS)) size_eff = SIZE_W'(MAX_RANKS);
    else size_eff = size_q;
    lmax = top_level(size_eff);
  end

  btcs_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .own_rank_i     (own_rank_q),
    .size_i         (size_eff),
    .lmax_i         (lmax),
    .init_excl_i    (init_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_action_i    (action_e'(s_axis_tuser)),
    .in_src_i       (s_axis_tdata[5:0]),
    .in_rx_empty_i  (s_axis_tdata[6]),
    .in_loc_empty_i (s_axis_tdata[7]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_o          (res)
  );

  assign m_axis_tdata = {6'b000000, res.self_excl, res.tree_level, res.partner};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

`ifndef SYNTH
  // a start beat always launches a walk
  a_start_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready &&
     (s_axis_tuser == ACT_START_RED || s_axis_tuser == ACT_START_BC))
    |=> !s_axis_tready)
    else $error("start beat did not launch a walk");

  // a beat held back by the sink stays put until it is taken
  a_hold_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
    (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
     $stable(m_axis_tlast)))
    else $error("stalled result beat changed");

  // a finished mark carries no partner or level and closes the event
  a_fin_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_FIN) |-> (m_axis_tdata[8:0] == 9'd0 && m_axis_tlast))
    else $error("malformed finished beat");

  // only sends may come before the closing beat
  a_mid_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == KIND_SEND))
    else $error("non-send beat without tlast");
`endif

endmodule

// File: tb/sv/binomial_tree_collective_scheduler_top_tb.sv
// Self-checking testbench for the binomial-tree reduce/broadcast scheduler top level.
module binomial_tree_collective_scheduler_top_tb;
  import btcs_pkg::*;

  // Cycles with no beat on any port before the run is declared hung. Event walks,
  // stalls, sender gaps and the drain pauses are far shorter than this.
  localparam int QUIET_LIMIT = 2000;
  // Settle time after the last result before a register write or the end.
  localparam int SETTLE_CYC  = 12;
  localparam int RAND_EVENTS = 180;

  // One row of the directed table: a register setting or one event beat.
  // Rows with fixed_res set carry their single result typed in.
  typedef struct {
    bit                is_cfg;
    logic [RANK_W-1:0] rank;
    logic [SIZE_W-1:0] size;
    logic [MAP_W-1:0]  excl;
    action_e           act;
    logic [RANK_W-1:0] src;
    logic              rx_empty;
    logic              loc_empty;
    bit                fixed_res;
    result_t           want;
  } stim_row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [1:0]        cfg_idx_i     = REG_OWN_RANK;
  logic [DATA_W-1:0] cfg_data_i    = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;  // [5:0] source_rank, [6] received_empty,
                                          // [7] local_empty
  logic [1:0]        s_axis_tuser  = ACT_START_RED;  // [1:0] action
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;   // [5:0] partner_rank, [8:6] tree_level, [9] self_excluded
  logic [1:0]        m_axis_tuser;   // [1:0] kind
  logic              m_axis_tlast;

  binomial_tree_collective_scheduler_top #(
    .MAX_RANKS(64)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scheduler mirror: own copy of the registers and of the rank's tree state.
  // ---------------------------------------------------------------------------
  logic [RANK_W-1:0] cfg_rank = '0;
  logic [SIZE_W-1:0] cfg_size = 7'd1;
  logic [MAP_W-1:0]  cfg_excl = '0;
  logic [MAP_W-1:0]  excl_map = '0;
  int                cur_lv   = 0;
  phase_e            ph       = PH_IDLE;

  result_t step_buf[$];   // steps caused by the event being planned
  result_t sched_q[$];    // steps still owed by the block, oldest first

  bit vld_drv    = 1'b0;  // what the sender last put on s_axis_tvalid
  bit idle_on    = 1'b1;  // random gaps and stalls enabled
  int busy_items = 0;     // accepted events that caused at least one step
  int err_cnt    = 0;
  int quiet_cyc  = 0;

  // Size 0 counts as a single rank, anything past 64 as 64.
  function automatic int clamp_size(input logic [SIZE_W-1:0] s);
    if (s == '0) return 1;
    if (s > 7'd64) return 64;
    return int'(s);
  endfunction

  // ceil(log2(size)) + 1
  function automatic int levels_for(input int size);
    int c;
    c = 0;
    while (c < 6 && (1 << c) < size) c++;
    return c + 1;
  endfunction

  task automatic put_step(input kind_e k, input int partner, input int lv);
    result_t s;
    s.kind       = k;
    s.partner    = partner[RANK_W-1:0];
    s.tree_level = lv[TL_W-1:0];
    s.self_excl  = excl_map[cfg_rank];
    s.last       = 1'b0;
    step_buf.push_back(s);
  endtask

  // Reduce: climb from level 'from'; stop at the first live child to wait on.
  task automatic walk_up(input int from, input logic loc_empty);
    int r, size, lmax, lv, p, half;
    r    = int'(cfg_rank);
    size = clamp_size(cfg_size);
    lmax = levels_for(size);
    for (lv = from; lv <= lmax; lv++) begin
      p    = 1 << lv;
      half = p >> 1;
      if (r % p == 0 && r + half < size) begin
        if (!excl_map[r + half]) begin
          put_step(KIND_RECV, r + half, lv);
          cur_lv = lv;
          ph     = PH_RED;
          return;
        end
      end else if (r % p == half) begin
        if (!excl_map[r - half]) put_step(KIND_SEND, r - half, lv);
      end
    end
    // empty local result drops this rank from the broadcast
    if (from <= lmax && loc_empty) excl_map[r] = 1'b1;
    ph = PH_IDLE;
    put_step(KIND_FIN, 0, 0);
  endtask

  // Broadcast: descend from level 'from'; stop at the parent to receive from.
  task automatic walk_down(input int from);
    int r, size, lv, p, half;
    r    = int'(cfg_rank);
    size = clamp_size(cfg_size);
    for (lv = from; lv >= 1; lv--) begin
      p    = 1 << lv;
      half = p >> 1;
      if (r % p == 0 && r + half < size) begin
        if (!excl_map[r + half]) put_step(KIND_SEND, r + half, lv);
      end else if (r % p == half) begin
        put_step(KIND_RECV, r - half, lv);
        cur_lv = lv;
        ph     = PH_BRC;
        return;
      end
    end
    ph = PH_IDLE;
    put_step(KIND_FIN, 0, 0);
  endtask

  // Works out the steps one accepted event causes into step_buf.
  task automatic plan_event(input action_e act, input logic [RANK_W-1:0] src,
                            input logic rx_empty, input logic loc_empty);
    int size;
    size = clamp_size(cfg_size);
    step_buf.delete();
    // arrivals outside the awaited phase are dropped without trace
    if (act == ACT_RED_MSG && ph != PH_RED) return;
    if (act == ACT_BC_MSG && ph != PH_BRC) return;
    if (act == ACT_START_RED) excl_map = cfg_excl;
    if (int'(cfg_rank) >= size) begin
      ph = PH_IDLE;
      put_step(KIND_FIN, 0, 0);
    end else begin
      case (act)
        ACT_START_RED: begin
          if (excl_map[cfg_rank]) begin
            ph = PH_IDLE;
            put_step(KIND_FIN, 0, 0);
          end else begin
            walk_up(1, loc_empty);
          end
        end
        ACT_RED_MSG: begin
          // an empty contribution excludes its sender
          if (rx_empty) excl_map[src] = 1'b1;
          walk_up(cur_lv + 1, loc_empty);
        end
        ACT_START_BC: begin
          if (excl_map[cfg_rank]) begin
            ph = PH_IDLE;
            put_step(KIND_FIN, 0, 0);
          end else begin
            walk_down(levels_for(size));
          end
        end
        default: walk_down(cur_lv > 0 ? cur_lv - 1 : 0);
      endcase
    end
    if (step_buf.size() != 0) step_buf[step_buf.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic stim_row_t evt(input action_e act, input logic [RANK_W-1:0] src,
                                    input logic rx_empty, input logic loc_empty);
    stim_row_t row;
    row           = '{default: '0, act: ACT_START_RED, want: result_t'('0)};
    row.act       = act;
    row.src       = src;
    row.rx_empty  = rx_empty;
    row.loc_empty = loc_empty;
    return row;
  endfunction

  // Event whose only step is a plain finished mark with the given own bit.
  function automatic stim_row_t evt_fin(input action_e act, input logic loc_empty,
                                        input logic self_excl);
    stim_row_t row;
    row                 = evt(act, '0, 1'b0, loc_empty);
    row.fixed_res       = 1'b1;
    row.want.kind       = KIND_FIN;
    row.want.partner    = '0;
    row.want.tree_level = '0;
    row.want.self_excl  = self_excl;
    row.want.last       = 1'b1;
    return row;
  endfunction

  function automatic stim_row_t cf(input logic [RANK_W-1:0] rank,
                                   input logic [SIZE_W-1:0] size,
                                   input logic [MAP_W-1:0] excl);
    stim_row_t row;
    row        = '{default: '0, act: ACT_START_RED, want: result_t'('0)};
    row.is_cfg = 1'b1;
    row.rank   = rank;
    row.size   = size;
    row.excl   = excl;
    return row;
  endfunction

  // Drops tvalid; must run in the same time step as the last accept.
  task automatic halt_sender();
    if (vld_drv) begin
      s_axis_tvalid <= 1'b0;
      vld_drv = 1'b0;
    end
  endtask

  task automatic drain();
    halt_sender();
    while (sched_q.size() != 0) @(posedge clk_i);
  endtask

  // Writes all three registers back to back once the block has gone quiet.
  task automatic configure(input logic [RANK_W-1:0] rank, input logic [SIZE_W-1:0] size,
                           input logic [MAP_W-1:0] excl);
    drain();
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_OWN_RANK;
    cfg_data_i <= DATA_W'(rank);
    cfg_rank    = rank;
    @(posedge clk_i);
    cfg_idx_i  <= REG_GROUP_SIZE;
    cfg_data_i <= DATA_W'(size);
    cfg_size    = size;
    @(posedge clk_i);
    cfg_idx_i  <= REG_INIT_EXCL;
    cfg_data_i <= excl;
    cfg_excl    = excl;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Presents one event beat and books the steps it causes once accepted.
  // tvalid stays up after the accept unless a random gap is picked, so the
  // next call may follow in the same step.
  task automatic send_event(input stim_row_t row);
    if (!vld_drv) begin
      @(posedge clk_i);
      while (idle_on && $urandom_range(99) < 11) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row.loc_empty, row.rx_empty, row.src};
    s_axis_tuser  <= row.act;
    vld_drv        = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    plan_event(row.act, row.src, row.rx_empty, row.loc_empty);
    if (row.fixed_res) begin
      step_buf.delete();
      step_buf.push_back(row.want);
    end
    if (step_buf.size() != 0) busy_items++;
    foreach (step_buf[i]) sched_q.push_back(step_buf[i]);
    if (idle_on && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      vld_drv = 1'b0;
    end
  endtask

  // Occasional stray beat: any action, any fields.
  task automatic maybe_noise();
    if ($urandom_range(9) == 0)
      send_event(evt(action_e'($urandom_range(3)), 6'($urandom_range(63)),
                     1'($urandom_range(1)), 1'($urandom_range(1))));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, beat checking, hang watchdog
  // ---------------------------------------------------------------------------
  task automatic report(input string msg);
    if (err_cnt < 100) $display("tb: mismatch: %s", msg);
    err_cnt++;
  endtask

  task automatic check_beat();
    result_t want;
    if (sched_q.size() == 0) begin
      report($sformatf("beat with nothing owed: kind %0d partner %0d level %0d",
                       m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[8:6]));
      return;
    end
    want = sched_q.pop_front();
    if (m_axis_tuser !== want.kind)
      report($sformatf("kind %0d, want %0d", m_axis_tuser, want.kind));
    if (m_axis_tdata[5:0] !== want.partner)
      report($sformatf("partner %0d, want %0d", m_axis_tdata[5:0], want.partner));
    if (m_axis_tdata[8:6] !== want.tree_level)
      report($sformatf("level %0d, want %0d", m_axis_tdata[8:6], want.tree_level));
    if (m_axis_tdata[9] !== want.self_excl)
      report($sformatf("self_excluded %b, want %b", m_axis_tdata[9], want.self_excl));
    if (m_axis_tlast !== want.last)
      report($sformatf("tlast %b, want %b", m_axis_tlast, want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_beat();
      m_axis_tready <= !(idle_on && $urandom_range(99) < 11);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  stim_row_t dir_tbl[$];

  initial begin
    int          sz;
    int          rk;
    logic [63:0] ex;
    int          guard;

    // directed table; typed results only where the answer is a bare finish
    dir_tbl.push_back(evt_fin(ACT_START_RED, 1'b0, 1'b0));     // reset values, one rank
    dir_tbl.push_back(evt(ACT_BC_MSG, 6'd5, 1'b0, 1'b0));      // arrival while idle
    dir_tbl.push_back(evt(ACT_START_BC, 6'd0, 1'b0, 1'b0));
    dir_tbl.push_back(cf(6'd0, 7'd64, 64'd0));
    dir_tbl.push_back(evt(ACT_START_RED, 6'd0, 1'b0, 1'b0));   // root waits on rank 1
    dir_tbl.push_back(evt(ACT_RED_MSG, 6'd1, 1'b1, 1'b0));     // empty sender
    dir_tbl.push_back(evt(ACT_RED_MSG, 6'd63, 1'b0, 1'b0));    // source not checked
    dir_tbl.push_back(evt(ACT_START_BC, 6'd0, 1'b0, 1'b0));    // restart mid-reduce
    dir_tbl.push_back(cf(6'd1, 7'd64, 64'd0));
    dir_tbl.push_back(evt(ACT_START_RED, 6'd0, 1'b0, 1'b1));   // empty local result
    dir_tbl.push_back(evt(ACT_START_BC, 6'd0, 1'b0, 1'b0));    // now self-excluded
    dir_tbl.push_back(evt(ACT_RED_MSG, 6'd0, 1'b1, 1'b1));     // arrival while idle
    dir_tbl.push_back(cf(6'd63, 7'd127, 64'h7fff_ffff_ffff_ffff));
    dir_tbl.push_back(evt(ACT_START_RED, 6'd0, 1'b0, 1'b0));
    dir_tbl.push_back(evt(ACT_START_BC, 6'd0, 1'b0, 1'b0));
    dir_tbl.push_back(evt(ACT_BC_MSG, 6'd62, 1'b1, 1'b1));
    dir_tbl.push_back(cf(6'd2, 7'd0, 64'd0));                  // size 0, rank outside
    dir_tbl.push_back(evt_fin(ACT_START_RED, 1'b1, 1'b0));
    dir_tbl.push_back(evt_fin(ACT_START_BC, 1'b0, 1'b0));
    dir_tbl.push_back(cf(6'd5, 7'd64, '1));
    dir_tbl.push_back(evt_fin(ACT_START_RED, 1'b0, 1'b1));     // excluded at start
    dir_tbl.push_back(cf(6'd4, 7'd8, 64'h0000_0000_0000_00a0));
    dir_tbl.push_back(evt(ACT_START_RED, 6'd0, 1'b0, 1'b0));
    dir_tbl.push_back(evt(ACT_START_RED, 6'd0, 1'b0, 1'b1));   // restart while waiting
    dir_tbl.push_back(evt(ACT_BC_MSG, 6'd5, 1'b0, 1'b0));      // wrong phase arrival

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg) configure(dir_tbl[i].rank, dir_tbl[i].size, dir_tbl[i].excl);
      else send_event(dir_tbl[i]);
    end

    // Random part: each pass picks a setting, then runs a full reduce and, in most
    // passes, a broadcast with random content, laced with stray beats.
    busy_items = 0;
    while (busy_items < RAND_EVENTS) begin
      // one long stretch with no gaps and no stalls
      idle_on = !(busy_items >= 70 && busy_items < 110);

      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0: sz = 0;
          1: sz = 64;
          2: sz = 127;
          default: sz = $urandom_range(127, 65);
        endcase
      end else begin
        sz = $urandom_range(64, 1);
      end
      if ($urandom_range(9) == 0) rk = $urandom_range(63);
      else rk = $urandom_range(clamp_size(sz[6:0]) - 1);
      case ($urandom_range(7))
        0: ex = '0;
        1: ex = '1;
        default: begin
          ex = {$urandom, $urandom} & {$urandom, $urandom};
          if ($urandom_range(3) != 0) ex[rk] = 1'b0;
        end
      endcase
      configure(rk[5:0], sz[6:0], ex);

      maybe_noise();
      send_event(evt(ACT_START_RED, 6'($urandom_range(63)), 1'($urandom_range(1)),
                     $urandom_range(4) == 0));
      guard = 0;
      while (ph == PH_RED && guard < 12) begin
        maybe_noise();
        send_event(evt(ACT_RED_MSG, 6'($urandom_range(63)), $urandom_range(3) == 0,
                       $urandom_range(4) == 0));
        guard++;
      end

      // sometimes hold the next event back until every step has come out
      if ($urandom_range(7) == 0) drain();

      if ($urandom_range(9) != 0) begin
        maybe_noise();
        send_event(evt(ACT_START_BC, 6'($urandom_range(63)), 1'($urandom_range(1)),
                       1'($urandom_range(1))));
        guard = 0;
        while (ph == PH_BRC && guard < 12) begin
          maybe_noise();
          send_event(evt(ACT_BC_MSG, 6'($urandom_range(63)), 1'($urandom_range(1)),
                         1'($urandom_range(1))));
          guard++;
        end
      end
    end

    drain();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/btcs_pkg.sv
design/btcs_level_unit.sv
design/btcs_seq.sv
design/binomial_tree_collective_scheduler_top.sv
tb/sv/binomial_tree_collective_scheduler_top_tb.sv
